[hw/rtl/assert_macros.svh]
// Assertion macros shared by the formatter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define AST_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Expression must never be true out of reset.
`define AST_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

[hw/rtl/iaf_pkg.sv]
// Types, format codes and character constants of the integer-to-ASCII formatter.
package iaf_pkg;

    localparam int VALUE_W        = 32;
    localparam int NUM_DIGITS     = 10;
    localparam int BCD_W          = 4 * NUM_DIGITS;
    localparam int DD_STAGES      = 8;
    localparam int DD_BITS        = VALUE_W / DD_STAGES;
    localparam int MAX_CHARS      = 16;
    localparam int LEN_W          = 5;
    localparam int CHAR_W         = 7;

    localparam logic [3:0] CMD_BIN8   = 4'd0;
    localparam logic [3:0] CMD_BIN16  = 4'd1;
    localparam logic [3:0] CMD_HEX8   = 4'd2;
    localparam logic [3:0] CMD_HEX16  = 4'd3;
    localparam logic [3:0] CMD_HEX32  = 4'd4;
    localparam logic [3:0] CMD_UDEC3  = 4'd5;
    localparam logic [3:0] CMD_UDEC5  = 4'd6;
    localparam logic [3:0] CMD_UDEC10 = 4'd7;
    localparam logic [3:0] CMD_DEC3   = 4'd8;
    localparam logic [3:0] CMD_DEC5   = 4'd9;
    localparam logic [3:0] CMD_DEC10  = 4'd10;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_ALPHA = 7'h37;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_X     = 7'h78;
    localparam logic [CHAR_W-1:0] CH_LOW   = 7'h20;
    localparam logic [CHAR_W-1:0] CH_HIGH  = 7'h78;

    typedef struct packed {
        logic [3:0]         command;
        logic [VALUE_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } text_t;

    typedef struct packed {
        logic [3:0]         command;
        logic               neg;
        logic [VALUE_W-1:0] bits;
    } work_t;

    typedef struct packed {
        logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
        logic [LEN_W-1:0]                 len;
    } line_t;

endpackage

[hw/rtl/integer_to_ascii_formatter_core.sv]
// Top level of the integer-to-ASCII formatter: decode, BCD pipeline, line build, serializer.
//
// Each request carries a format code and a 32-bit value and yields its ASCII text, one
// character per output request, the final one flagged with last. A request passes a
// decode stage, eight binary-to-BCD stages and a line-build stage before its first character
// is presented; a new request can enter every cycle while the pipeline has room. Sustained
// throughput is set by the single-character output port, which sends one character at a
// time: a number has 8 or 16 characters for binary, 4, 6 or 10 for hex, 3 to 11 for
// decimal. Format codes 11 to 15 are accepted and produce no output.
`include "assert_macros.svh"

module integer_to_ascii_formatter_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  iaf_pkg::item_t  item,
    output logic            text_valid,
    input  logic            text_ready,
    output iaf_pkg::text_t  text
);

    import iaf_pkg::*;

    logic               s0_valid_reg;
    logic               s0_valid_next;
    work_t              s0_work_reg;
    work_t              s0_work_next;
    logic               fmt_valid_reg;
    logic               fmt_valid_next;
    line_t              fmt_line_reg;
    line_t              fmt_line_next;

    logic [VALUE_W-1:0] mask;
    logic [VALUE_W-1:0] masked;
    logic               sign_bit;
    logic               is_signed;
    logic               cmd_ok;
    work_t              decoded;

    logic               pipe_in_ready;
    logic               pipe_out_valid;
    logic               pipe_out_ready;
    work_t              pipe_out_work;
    logic [BCD_W-1:0]   pipe_out_bcd;
    logic               ser_in_ready;

    logic [CHAR_W-1:0]  dchar [NUM_DIGITS];
    logic               zero_above;
    logic               is_dec;
    logic [3:0]         ndig;
    logic [3:0]         idx;

    function automatic logic [CHAR_W-1:0] hex_char(logic [3:0] nib);
        return (nib < 4'd10) ? (CH_ZERO + {3'b000, nib}) : (CH_ALPHA + {3'b000, nib});
    endfunction

    always_comb
    begin
        case (item.command)
            CMD_BIN8, CMD_HEX8, CMD_UDEC3, CMD_DEC3:     mask = 32'h0000_00FF;
            CMD_BIN16, CMD_HEX16, CMD_UDEC5, CMD_DEC5:   mask = 32'h0000_FFFF;
            default:                                     mask = 32'hFFFF_FFFF;
        endcase
        case (item.command)
            CMD_DEC3:  sign_bit = item.value[7];
            CMD_DEC5:  sign_bit = item.value[15];
            CMD_DEC10: sign_bit = item.value[31];
            default:   sign_bit = 1'b0;
        endcase
        is_signed = (item.command == CMD_DEC3) || (item.command == CMD_DEC5)
                 || (item.command == CMD_DEC10);
        cmd_ok    = (item.command <= CMD_DEC10);
        masked    = item.value & mask;
        decoded.command = item.command;
        decoded.neg     = is_signed && sign_bit;
        decoded.bits    = decoded.neg ? ((~masked + VALUE_W'(1)) & mask) : masked;
    end

    assign item_ready    = !s0_valid_reg || pipe_in_ready;
    assign s0_valid_next = item_ready ? (item_valid && cmd_ok) : s0_valid_reg;
    assign s0_work_next  = item_ready ? decoded : s0_work_reg;

    iaf_bcd_pipe u_bcd (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_valid_reg),
        .in_ready  (pipe_in_ready),
        .in_work   (s0_work_reg),
        .out_valid (pipe_out_valid),
        .out_ready (pipe_out_ready),
        .out_work  (pipe_out_work),
        .out_bcd   (pipe_out_bcd)
    );

    always_comb
    begin
        zero_above = 1'b1;
        for (int k = NUM_DIGITS - 1; k >= 0; k--) begin
            zero_above = zero_above && (pipe_out_bcd[4*k +: 4] == 4'd0);
            // blank leading zeros, keep the units digit
            if (zero_above && (k != 0))
            begin
                dchar[k] = CH_SPACE;
            end
            else
            begin
                dchar[k] = CH_ZERO + {3'b000, pipe_out_bcd[4*k +: 4]};
            end
        end
    end

    always_comb
    begin
        fmt_line_next.chars = '0;
        fmt_line_next.len   = '0;
        is_dec = 1'b0;
        ndig   = 4'd0;
        idx    = 4'd0;
        case (pipe_out_work.command)
            CMD_BIN8:
            begin
                for (int p = 0; p < 8; p++) begin
                    fmt_line_next.chars[p] = CH_ZERO + CHAR_W'(pipe_out_work.bits[7-p]);
                end
                fmt_line_next.len = LEN_W'(8);
            end
            CMD_BIN16:
            begin
                for (int p = 0; p < 16; p++) begin
                    fmt_line_next.chars[p] = CH_ZERO + CHAR_W'(pipe_out_work.bits[15-p]);
                end
                fmt_line_next.len = LEN_W'(16);
            end
            CMD_HEX8:
            begin
                fmt_line_next.chars[0] = CH_ZERO;
                fmt_line_next.chars[1] = CH_X;
                for (int p = 0; p < 2; p++) begin
                    fmt_line_next.chars[2+p] = hex_char(pipe_out_work.bits[4*(1-p) +: 4]);
                end
                fmt_line_next.len = LEN_W'(4);
            end
            CMD_HEX16:
            begin
                fmt_line_next.chars[0] = CH_ZERO;
                fmt_line_next.chars[1] = CH_X;
                for (int p = 0; p < 4; p++) begin
                    fmt_line_next.chars[2+p] = hex_char(pipe_out_work.bits[4*(3-p) +: 4]);
                end
                fmt_line_next.len = LEN_W'(6);
            end
            CMD_HEX32:
            begin
                fmt_line_next.chars[0] = CH_ZERO;
                fmt_line_next.chars[1] = CH_X;
                for (int p = 0; p < 8; p++) begin
                    fmt_line_next.chars[2+p] = hex_char(pipe_out_work.bits[4*(7-p) +: 4]);
                end
                fmt_line_next.len = LEN_W'(10);
            end
            CMD_UDEC3, CMD_DEC3:
            begin
                is_dec = 1'b1;
                ndig   = 4'd3;
            end
            CMD_UDEC5, CMD_DEC5:
            begin
                is_dec = 1'b1;
                ndig   = 4'd5;
            end
            CMD_UDEC10, CMD_DEC10:
            begin
                is_dec = 1'b1;
                ndig   = 4'd10;
            end
            default:
            begin
                is_dec = 1'b0;
            end
        endcase
        if (is_dec)
        begin
            if (pipe_out_work.neg)
            begin
                fmt_line_next.chars[0] = CH_MINUS;
            end
            for (int p = 0; p < NUM_DIGITS; p++) begin
                if (4'(p) < ndig)
                begin
                    idx = ndig - 4'(p) - 4'd1;
                    if (pipe_out_work.neg)
                    begin
                        fmt_line_next.chars[4'(p + 1)] = dchar[idx];
                    end
                    else
                    begin
                        fmt_line_next.chars[4'(p)] = dchar[idx];
                    end
                end
            end
            fmt_line_next.len = LEN_W'(ndig) + LEN_W'(pipe_out_work.neg);
        end
    end

    assign pipe_out_ready = !fmt_valid_reg || ser_in_ready;
    assign fmt_valid_next = pipe_out_ready ? pipe_out_valid : fmt_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            fmt_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg  <= s0_valid_next;
            fmt_valid_reg <= fmt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_work_reg <= s0_work_next;
        if (pipe_out_ready)
        begin
            fmt_line_reg <= fmt_line_next;
        end
    end

    iaf_serializer u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fmt_valid_reg),
        .in_ready  (ser_in_ready),
        .in_line   (fmt_line_reg),
        .out_valid (text_valid),
        .out_ready (text_ready),
        .out_text  (text)
    );

    `AST_ALWAYS(a_fmt_len, fmt_valid_reg |-> (fmt_line_reg.len != '0 && fmt_line_reg.len <= LEN_W'(MAX_CHARS)), "formatted line has bad length")
    `AST_ALWAYS(a_s0_code, s0_valid_reg |-> s0_work_reg.command <= CMD_DEC10, "unused format code entered the pipeline")
    `AST_ALWAYS(a_s0_neg, (s0_valid_reg && s0_work_reg.neg) |-> s0_work_reg.command >= CMD_DEC3, "negative flag on an unsigned format")
    `AST_ALWAYS(a_fmt_hold, (fmt_valid_reg && !ser_in_ready) |=> fmt_valid_reg && $stable(fmt_line_reg), "stalled line changed")

endmodule

[hw/rtl/iaf_bcd_pipe.sv]
// Pipelined binary-to-BCD conversion, four shift-and-add-3 steps per stage.
module iaf_bcd_pipe (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  iaf_pkg::work_t              in_work,
    output logic                        out_valid,
    input  logic                        out_ready,
    output iaf_pkg::work_t              out_work,
    output logic [iaf_pkg::BCD_W-1:0]   out_bcd
);

    import iaf_pkg::*;

    logic [DD_STAGES-1:0] valid_reg;
    logic [DD_STAGES-1:0] valid_next;
    logic [DD_STAGES-1:0] stage_ready;
    work_t                work_reg   [DD_STAGES];
    work_t                work_next  [DD_STAGES];
    logic [VALUE_W-1:0]   shift_reg  [DD_STAGES];
    logic [VALUE_W-1:0]   shift_next [DD_STAGES];
    logic [BCD_W-1:0]     bcd_reg    [DD_STAGES];
    logic [BCD_W-1:0]     bcd_next   [DD_STAGES];
    logic [VALUE_W-1:0]   src_shift  [DD_STAGES];
    logic [BCD_W-1:0]     src_bcd    [DD_STAGES];
    logic [DD_STAGES-1:0] src_valid;
    work_t                src_work   [DD_STAGES];

    function automatic logic [BCD_W-1:0] dd_step(logic [BCD_W-1:0] bcd, logic b);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (adj[4*k +: 4] >= 4'd5)
            begin
                adj[4*k +: 4] = adj[4*k +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], b};
    endfunction

    always_comb
    begin
        src_valid[0] = in_valid;
        src_work[0]  = in_work;
        src_shift[0] = in_work.bits;
        src_bcd[0]   = '0;
        for (int s = 1; s < DD_STAGES; s++) begin
            src_valid[s] = valid_reg[s-1];
            src_work[s]  = work_reg[s-1];
            src_shift[s] = shift_reg[s-1];
            src_bcd[s]   = bcd_reg[s-1];
        end
    end

    always_comb
    begin
        stage_ready[DD_STAGES-1] = !valid_reg[DD_STAGES-1] || out_ready;
        for (int s = DD_STAGES - 2; s >= 0; s--) begin
            stage_ready[s] = !valid_reg[s] || stage_ready[s+1];
        end
    end

    always_comb
    begin
        for (int s = 0; s < DD_STAGES; s++) begin
            shift_next[s] = src_shift[s];
            bcd_next[s]   = src_bcd[s];
            for (int j = 0; j < DD_BITS; j++) begin
                bcd_next[s]   = dd_step(bcd_next[s], shift_next[s][VALUE_W-1]);
                shift_next[s] = {shift_next[s][VALUE_W-2:0], 1'b0};
            end
            work_next[s]  = src_work[s];
            valid_next[s] = stage_ready[s] ? src_valid[s] : valid_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DD_STAGES; s++) begin
            if (stage_ready[s])
            begin
                work_reg[s]  <= work_next[s];
                shift_reg[s] <= shift_next[s];
                bcd_reg[s]   <= bcd_next[s];
            end
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[DD_STAGES-1];
    assign out_work  = work_reg[DD_STAGES-1];
    assign out_bcd   = bcd_reg[DD_STAGES-1];

endmodule

[hw/rtl/iaf_serializer.sv]
// Character serializer: loads one formatted line and sends one character per cycle while out_ready is high.
`include "assert_macros.svh"

module iaf_serializer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  iaf_pkg::line_t  in_line,
    output logic            out_valid,
    input  logic            out_ready,
    output iaf_pkg::text_t  out_text
);

    import iaf_pkg::*;

    logic [LEN_W-1:0]                 count_reg;
    logic [LEN_W-1:0]                 count_next;
    logic [MAX_CHARS-1:0][CHAR_W-1:0] chars_reg;
    logic [MAX_CHARS-1:0][CHAR_W-1:0] chars_next;
    logic                             load;
    logic                             take;

    assign out_valid = (count_reg != '0);
    assign in_ready  = (count_reg == '0) || ((count_reg == LEN_W'(1)) && out_ready);
    assign take      = out_valid && out_ready;
    assign load      = in_valid && in_ready;

    always_comb
    begin
        chars_next = chars_reg;
        count_next = count_reg;
        if (load)
        begin
            chars_next = in_line.chars;
            count_next = in_line.len;
        end
        else if (take)
        begin
            // advance to the next character
            for (int i = 0; i < MAX_CHARS - 1; i++) begin
                chars_next[i] = chars_reg[i+1];
            end
            chars_next[MAX_CHARS-1] = CH_SPACE;
            count_next = count_reg - LEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chars_reg <= chars_next;
    end

    assign out_text.char_code = chars_reg[0];
    assign out_text.last      = (count_reg == LEN_W'(1));

    `AST_ALWAYS(a_load_len, load |=> count_reg == $past(in_line.len), "count differs from loaded length")
    `AST_ALWAYS(a_count_step, (take && !load) |=> count_reg == $past(count_reg) - LEN_W'(1), "count did not step down on a taken character")
    `AST_ALWAYS(a_char_range, out_valid |-> (out_text.char_code >= CH_LOW && out_text.char_code <= CH_HIGH), "character code out of range")
    `AST_NEVER(a_count_max, count_reg > LEN_W'(MAX_CHARS), "count above line capacity")

endmodule
